// ===== rtl/ole_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ole_pkg
// Shared constants and types for the ordered list engine.
// ----------------------------------------------------------------------------
package ole_pkg;

  localparam int DATA_W      = 32;
  localparam int FUNC_W      = 3;
  localparam int STATUS_W    = 2;
  localparam int POS_W       = 4;
  localparam int COUNT_W     = 5;
  localparam int CAPACITY_DEF = 16;

  localparam logic [FUNC_W-1:0] FN_INS_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INS_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_RM_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_RM_BACK   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_RM_MATCH  = 3'd4;
  localparam logic [FUNC_W-1:0] FN_FIND      = 3'd5;
  localparam logic [FUNC_W-1:0] FN_REVERSE   = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  // broadcast controls for every cell
  typedef struct packed {
    logic ins_low;
    logic ins_high;
    logic match_en;
    logic rm_match;
    logic reversed;
  } cell_ctl_t;

  // where a cell sits relative to the fill level
  typedef struct packed {
    logic used;
    logic tail;
    logic open_end;
  } cell_slot_t;

endpackage
`default_nettype wire

// ===== rtl/ole_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ole_in_if
// Command channel: function code and value or key.
// ----------------------------------------------------------------------------
interface ole_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic signed [31:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink (input valid, input func, input value, output ready);
endinterface
`default_nettype wire

// ===== rtl/ole_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ole_out_if
// Response channel: status, data, position and count.
// ----------------------------------------------------------------------------
interface ole_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic signed [31:0] data_out;
  logic [3:0]  position;
  logic [4:0]  count;

  modport source (output valid, output status, output data_out, output position,
                  output count, input ready);
  modport sink (input valid, input status, input data_out, input position,
                input count, output ready);
endinterface
`default_nettype wire

// ===== rtl/ordered_list_engine_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_engine_top
// Bounded ordered list of signed 32-bit values with search and delete.
//
// cmd carries a function code and a value or key; rsp returns one beat per
// command with status, removed or found data, match position and new count.
// Entries live in a row of CAPACITY cells, packed from slot 0; a reverse only
// flips which end counts as the front. Inserts shift the whole row up or load
// the open slot, removals close the gap by shifting the upper cells down, and
// every cell compares the key at once with a first-match chain along the row.
// The response is registered and shows in the cycle after the command beat,
// and a new command is taken every cycle while rsp is
// taken. The first-match and gap-closing chains through the cells set the
// clock period. If the receiver stalls, the response holds and cmd.ready drops
// until it is taken. Reset empties the list and clears the reverse flag; cell
// contents are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
module ordered_list_engine_top
  import ole_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  ole_in_if.sink    cmd,
  ole_out_if.source rsp
);

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int SLOT_W = $clog2(CAPACITY);

  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             reversed;
  logic             accept;

  logic                     full;
  logic                     empty;
  logic                     ins;
  logic                     rm;
  logic                     rm_low;
  logic                     found;
  cell_ctl_t                ctl;
  logic [CAPACITY-1:0]      hit;
  logic [CAPACITY-1:0]      seen_lo;
  logic [CAPACITY-1:0]      seen_hi;
  logic [CAPACITY-1:0]      close_chain;
  logic signed [DATA_W-1:0] vals [CAPACITY];
  logic signed [DATA_W-1:0] tails [CAPACITY];
  logic signed [DATA_W-1:0] tail_data;
  logic [SLOT_W-1:0]        hit_slot;
  logic [CNT_W-1:0]         pos_calc;

  logic [STATUS_W-1:0]      status_next;
  logic signed [DATA_W-1:0] data_next;

  assign accept    = cmd.valid && cmd.ready;
  assign cmd.ready = !rst && (!rsp.valid || rsp.ready);

  assign full  = (cnt == CNT_W'(CAPACITY));
  assign empty = (cnt == '0);

  assign ins    = ((cmd.func == FN_INS_FRONT) || (cmd.func == FN_INS_BACK)) && !full;
  assign rm     = ((cmd.func == FN_RM_FRONT) || (cmd.func == FN_RM_BACK)) && !empty;
  assign rm_low = rm && ((cmd.func == FN_RM_FRONT) != reversed);

  always_comb begin
    ctl          = '0;
    ctl.reversed = reversed;
    if (accept) begin
      ctl.ins_low  = ins && ((cmd.func == FN_INS_FRONT) != reversed);
      ctl.ins_high = ins && ((cmd.func == FN_INS_FRONT) == reversed);
      ctl.rm_match = (cmd.func == FN_RM_MATCH);
    end
    ctl.match_en = (cmd.func == FN_RM_MATCH) || (cmd.func == FN_FIND);
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    cell_slot_t               slot;
    logic signed [DATA_W-1:0] lo_val;
    logic signed [DATA_W-1:0] hi_val;
    logic                     lo_seen;
    logic                     hi_seen;
    logic                     close_in;

    assign slot.used     = CNT_W'(k) < cnt;
    assign slot.tail     = CNT_W'(k + 1) == cnt;
    assign slot.open_end = CNT_W'(k) == cnt;

    if (k == 0) begin : g_first
      assign lo_val   = cmd.value;
      assign lo_seen  = 1'b0;
      assign close_in = accept && rm_low;
    end else begin : g_mid
      assign lo_val   = vals[k-1];
      assign lo_seen  = seen_lo[k-1];
      assign close_in = close_chain[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign hi_val  = vals[k];
      assign hi_seen = 1'b0;
    end else begin : g_inner
      assign hi_val  = vals[k+1];
      assign hi_seen = seen_hi[k+1];
    end

    ole_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .slot        (slot),
      .key         (cmd.value),
      .lo_val      (lo_val),
      .hi_val      (hi_val),
      .seen_lo_in  (lo_seen),
      .seen_hi_in  (hi_seen),
      .close_in    (close_in),
      .val         (vals[k]),
      .seen_lo_out (seen_lo[k]),
      .seen_hi_out (seen_hi[k]),
      .close_out   (close_chain[k]),
      .hit         (hit[k]),
      .tail_val    (tails[k])
    );
  end

  assign found = |hit;

  always_comb begin
    tail_data = '0;
    hit_slot  = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      tail_data = tail_data | tails[k];
      hit_slot  = hit_slot | (hit[k] ? SLOT_W'(k) : '0);
    end
  end

  assign pos_calc = reversed ? (cnt - CNT_W'(1) - CNT_W'(hit_slot)) : CNT_W'(hit_slot);

  always_comb begin
    status_next = ST_OK;
    data_next   = '0;
    cnt_next    = cnt;
    case (cmd.func)
      FN_INS_FRONT, FN_INS_BACK: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      FN_RM_FRONT, FN_RM_BACK: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          data_next = rm_low ? vals[0] : tail_data;
          cnt_next  = cnt - CNT_W'(1);
        end
      end
      FN_RM_MATCH, FN_FIND: begin
        if (found) begin
          data_next = cmd.value;
          if (cmd.func == FN_RM_MATCH) begin
            cnt_next = cnt - CNT_W'(1);
          end
        end else begin
          status_next = ST_NOTFOUND;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      reversed  <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (accept) begin
        cnt       <= cnt_next;
        rsp.valid <= 1'b1;
        if (cmd.func == FN_REVERSE) begin
          reversed <= !reversed;
        end
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status   <= status_next;
      rsp.data_out <= data_next;
      rsp.position <= found ? POS_W'(pos_calc) : '0;
      rsp.count    <= COUNT_W'(cnt_next);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(CAPACITY))
    else $error("list count above capacity");

  a_one_hit: assert property (@(posedge clk) disable iff (rst)
    $onehot0(hit))
    else $error("more than one cell selected as first match");

  a_full_refuse: assert property (@(posedge clk) disable iff (rst)
    accept && full && ((cmd.func == FN_INS_FRONT) || (cmd.func == FN_INS_BACK))
    |=> rsp.status == ST_FULL && $stable(cnt))
    else $error("insert into full list not refused");

  a_reverse: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd.func == FN_REVERSE) |=> reversed != $past(reversed) && $stable(cnt))
    else $error("reverse did not flip order alone");

endmodule
`default_nettype wire

// ===== rtl/ole_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ole_cell
// One list slot: holds a value, compares the key, shifts with its neighbors.
// ----------------------------------------------------------------------------
module ole_cell
  import ole_pkg::*;
(
  input  wire logic                     clk,
  input  wire cell_ctl_t                ctl,
  input  wire cell_slot_t               slot,
  input  wire logic signed [DATA_W-1:0] key,
  input  wire logic signed [DATA_W-1:0] lo_val,
  input  wire logic signed [DATA_W-1:0] hi_val,
  input  wire logic                     seen_lo_in,
  input  wire logic                     seen_hi_in,
  input  wire logic                     close_in,
  output logic signed [DATA_W-1:0]      val,
  output logic                          seen_lo_out,
  output logic                          seen_hi_out,
  output logic                          close_out,
  output logic                          hit,
  output logic signed [DATA_W-1:0]      tail_val
);

  logic match;

  assign match       = ctl.match_en && slot.used && (val == key);
  assign seen_lo_out = seen_lo_in | match;
  assign seen_hi_out = seen_hi_in | match;
  assign hit         = match && (ctl.reversed ? !seen_hi_in : !seen_lo_in);
  assign close_out   = close_in | (hit & ctl.rm_match);
  assign tail_val    = slot.tail ? val : '0;

  always_ff @(posedge clk) begin
    if (ctl.ins_low) begin
      val <= lo_val;
    end else if (ctl.ins_high && slot.open_end) begin
      val <= key;
    end else if (close_out) begin
      val <= hi_val;
    end
  end

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ordered list engine.
//
// Commands go in on the cmd channel. A scoreboard keeps its own copy of the list
// in front-to-back order and works out the response to every accepted command.
// Each response beat is compared field by field with the oldest one waiting.
// A short directed run covers empty-list answers, extreme values, duplicates,
// reverse and the unused code. Random phases then lean toward inserting or
// removing, so the list swings between empty and full. Keys mostly come from
// the entries held, so searches and removals by key hit often.
// ----------------------------------------------------------------------------
module tb_top;
  import ole_pkg::*;

  localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] data_out;
    logic [POS_W-1:0]         position;
    logic [COUNT_W-1:0]       count;
  } list_rsp_t;

  class list_scoreboard;
    logic signed [DATA_W-1:0] held_q[$];
    list_rsp_t pending_rsp[$];
    int mismatches = 0;

    task report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    function void apply_cmd(input logic [FUNC_W-1:0] func, input logic signed [DATA_W-1:0] value);
      list_rsp_t r;
      logic signed [DATA_W-1:0] flipped_q[$];
      int hit;
      r.status = ST_OK;
      r.data_out = '0;
      r.position = '0;
      case (func)
        FN_INS_FRONT, FN_INS_BACK: begin
          if (held_q.size() >= CAPACITY_DEF) r.status = ST_FULL;
          else if (func == FN_INS_FRONT) held_q.push_front(value);
          else held_q.push_back(value);
        end
        FN_RM_FRONT, FN_RM_BACK: begin
          if (held_q.size() == 0) r.status = ST_EMPTY;
          else if (func == FN_RM_FRONT) r.data_out = held_q.pop_front();
          else r.data_out = held_q.pop_back();
        end
        FN_RM_MATCH, FN_FIND: begin
          hit = -1;
          for (int i = 0; i < held_q.size(); i++) begin
            if (hit < 0 && held_q[i] == value) hit = i;
          end
          if (hit < 0) begin
            r.status = ST_NOTFOUND;
          end else begin
            r.data_out = value;
            r.position = hit[POS_W-1:0];
            if (func == FN_RM_MATCH) held_q.delete(hit);
          end
        end
        FN_REVERSE: begin
          foreach (held_q[i]) flipped_q.push_front(held_q[i]);
          held_q = flipped_q;
        end
        default: ;
      endcase
      r.count = COUNT_W'(held_q.size());
      pending_rsp.push_back(r);
    endfunction

    task check_rsp(input logic [STATUS_W-1:0] status, input logic signed [DATA_W-1:0] data_out,
                   input logic [POS_W-1:0] position, input logic [COUNT_W-1:0] count);
      list_rsp_t exp_rsp;
      if (pending_rsp.size() == 0) begin
        report_mismatch("response beat with nothing expected");
      end else begin
        exp_rsp = pending_rsp.pop_front();
        if (status !== exp_rsp.status)
          report_mismatch($sformatf("status %0d, expected %0d", status, exp_rsp.status));
        if (data_out !== exp_rsp.data_out)
          report_mismatch($sformatf("data_out %0d, expected %0d", data_out, exp_rsp.data_out));
        if (position !== exp_rsp.position)
          report_mismatch($sformatf("position %0d, expected %0d", position, exp_rsp.position));
        if (count !== exp_rsp.count)
          report_mismatch($sformatf("count %0d, expected %0d", count, exp_rsp.count));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit idle_on = 1'b1;
  int stall_left = 0;
  int cycle_count = 0;
  list_scoreboard sb = new();

  ole_in_if  cmd_if();
  ole_out_if rsp_if();

  ordered_list_engine_top u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .rsp (rsp_if)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
      sb.check_rsp(rsp_if.status, rsp_if.data_out, rsp_if.position, rsp_if.count);
  end

  // response side stalls in bursts
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        rsp_if.ready = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        rsp_if.ready = 1'b0;
        stall_left = $urandom_range(1, 5) - 1;
      end else begin
        rsp_if.ready = 1'b1;
      end
    end
  end

  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 3))
      0, 1: v = $signed($urandom_range(0, 8)) - 4;
      2: v = $urandom;
      default: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7fff_ffff;
          2: v = '0;
          default: v = -1;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_key();
    if (sb.held_q.size() > 0 && $urandom_range(0, 9) < 7)
      return sb.held_q[$urandom_range(0, sb.held_q.size() - 1)];
    return pick_value();
  endfunction

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_cmd(input logic [FUNC_W-1:0] func, input logic signed [DATA_W-1:0] value);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      cmd_if.valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    cmd_if.func = func;
    cmd_if.value = value;
    cmd_if.valid = 1'b1;
    do @(posedge clk); while (cmd_if.ready !== 1'b1);
    sb.apply_cmd(func, value);
    @(negedge clk);
  endtask

  // ins_pct sets how hard the phase pushes toward a full list
  task automatic run_phase(input int n, input int ins_pct);
    int r;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < ins_pct) begin
        send_cmd($urandom_range(0, 1) ? FN_INS_FRONT : FN_INS_BACK, pick_value());
      end else begin
        r = $urandom_range(0, 99);
        if (r < 20) send_cmd(FN_RM_FRONT, pick_value());
        else if (r < 40) send_cmd(FN_RM_BACK, pick_value());
        else if (r < 65) send_cmd(FN_RM_MATCH, pick_key());
        else if (r < 90) send_cmd(FN_FIND, pick_key());
        else if (r < 98) send_cmd(FN_REVERSE, pick_value());
        else send_cmd(FN_UNUSED, pick_value());
      end
    end
  endtask

  initial begin
    cmd_if.valid = 1'b0;
    cmd_if.func = FN_INS_FRONT;
    cmd_if.value = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty list answers
    send_cmd(FN_RM_FRONT, 32'sd0);
    send_cmd(FN_RM_BACK, -1);
    send_cmd(FN_RM_MATCH, 32'sd5);
    send_cmd(FN_FIND, 32'sd5);
    send_cmd(FN_REVERSE, 32'sd0);
    send_cmd(FN_UNUSED, -1);
    // single entry reverse, then extremes and duplicates
    send_cmd(FN_INS_FRONT, 32'sh7fff_ffff);
    send_cmd(FN_REVERSE, 32'sd0);
    send_cmd(FN_INS_BACK, 32'sh8000_0000);
    send_cmd(FN_INS_FRONT, -1);
    send_cmd(FN_INS_BACK, 32'sd0);
    send_cmd(FN_INS_BACK, -1);
    send_cmd(FN_FIND, -1);
    send_cmd(FN_REVERSE, 32'sd0);
    send_cmd(FN_FIND, -1);
    send_cmd(FN_FIND, 32'sh8000_0000);
    send_cmd(FN_RM_MATCH, -1);
    send_cmd(FN_RM_MATCH, 32'sd1234);
    send_cmd(FN_UNUSED, 32'sh7fff_ffff);
    send_cmd(FN_RM_FRONT, 32'sd0);
    send_cmd(FN_RM_BACK, 32'sd0);
    send_cmd(FN_REVERSE, 32'sd0);
    send_cmd(FN_RM_BACK, 32'sd0);
    send_cmd(FN_RM_FRONT, 32'sd0);

    run_phase(150, 75);
    run_phase(150, 25);
    run_phase(150, 60);
    run_phase(150, 40);
    idle_on = 1'b0;
    run_phase(150, 50);

    cmd_if.valid = 1'b0;
    while (sb.pending_rsp.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
